>>> hw/rtl/uwt_pkg.sv
// shared types, codes and defaults of the identifier table
package uwt_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned IdBytesDef    = 10;

  // identifier bytes carried by the ports (bytes 0..7 low, 8..9 high)
  localparam int unsigned IdBytesMax = 10;
  localparam int unsigned IdBitsMax  = 8 * IdBytesMax;

  // command codes
  typedef enum logic [2:0] {
    ActAdd    = 3'd0,
    ActRemove = 3'd1,
    ActLookup = 3'd2,
    ActClear  = 3'd3,
    ActRead   = 3'd4
  } action_e;

  // result status codes
  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StInvalid = 3'd1,
    StExists  = 3'd2,
    StFull    = 3'd3,
    StMissing = 3'd4
  } status_e;

  // controller sequence
  typedef enum logic [1:0] {
    CtlIdle,
    CtlSearch,
    CtlApply
  } ctl_state_e;

  // one table entry
  typedef struct packed {
    logic [63:0] lo;
    logic [15:0] hi;
    logic [3:0]  len;
    logic [7:0]  kind;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    entry_t                  key;
    logic [IdBytesMax-1:0]   byte_en;
    logic                    search;
    logic                    by_index;
    logic                    append;
    logic                    shift;
    logic [7:0]              index;
    logic [7:0]              count;
  } cell_bcast_t;

endpackage

>>> hw/rtl/uwt_cell.sv
// one table cell: holds an entry, compares it with the key and shifts from its neighbour
module uwt_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  uwt_pkg::cell_bcast_t bcast_i,
  input  uwt_pkg::entry_t      next_i,
  output uwt_pkg::entry_t      entry_o,
  output logic                 hit_o
);

  localparam logic [7:0] Pos     = 8'(Idx);
  localparam logic [8:0] PosNext = 9'(Idx + 1);

  uwt_pkg::entry_t                entry_q, entry_d;
  logic                           hit_q, hit_d;
  logic                           occupied;
  logic                           same_key;
  logic [uwt_pkg::IdBitsMax-1:0]  bit_en;
  logic [uwt_pkg::IdBitsMax-1:0]  diff;

  // compare against the broadcast key over the first length bytes
  always_comb begin
    occupied = (Pos < bcast_i.count);
    for (int b = 0; b < uwt_pkg::IdBytesMax; b++) begin
      bit_en[b*8 +: 8] = {8{bcast_i.byte_en[b]}};
    end
    diff     = ({entry_q.hi, entry_q.lo} ^ {bcast_i.key.hi, bcast_i.key.lo}) & bit_en;
    same_key = (entry_q.len == bcast_i.key.len) && (diff == '0);
  end

  // hit flag, by key or by position
  always_comb begin
    hit_d = hit_q;
    if (bcast_i.search) begin
      hit_d = occupied && (bcast_i.by_index ? (Pos == bcast_i.index) : same_key);
    end
  end

  // entry update: append at the fill position, or close a gap
  always_comb begin
    entry_d = entry_q;
    priority if (bcast_i.append && (Pos == bcast_i.index)) begin
      entry_d = bcast_i.key;
    end else if (bcast_i.shift && (Pos >= bcast_i.index) &&
                 (PosNext < {1'b0, bcast_i.count})) begin
      entry_d = next_i;
    end else begin
      entry_d = entry_q;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // hit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

>>> hw/rtl/uid_whitelist_table_unit.sv
// ordered table of card identifiers built as a row of compare-and-shift cells
//
// Command channel: a beat is taken at a rising edge with start_i high and
// busy_o low. It carries action_i, the identifier (id_low_i, id_high_i,
// id_length_i), card_kind_i for add and entry_index_i for read.
// Result channel: done_o is high for exactly one cycle with status_o,
// present_o, match_index_o, entry_total_o and the read_* fields; the
// receiver cannot stall, so the result must be taken in that cycle.
// Sequence: the cycle after the accepting edge every cell compares its
// entry with the key in parallel, the next cycle the single hit is
// encoded and the row appends or shifts or the count is cleared, and
// done_o is high in the cycle after that. busy_o is high during the
// compare and update cycles, so a new command can be taken in the cycle
// done_o is high, but not before the compare then update sequence
// through the cell row is done.
// Reset empties the table (count to zero) and drops any command in flight;
// the entry storage itself is not cleared, as only entries below the count
// are ever compared or read.
module uid_whitelist_table_unit #(
  parameter int unsigned TABLE_DEPTH = uwt_pkg::TableDepthDef,
  parameter int unsigned ID_BYTES    = uwt_pkg::IdBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [63:0] id_low_i,
  input  logic [15:0] id_high_i,
  input  logic [3:0]  id_length_i,
  input  logic [7:0]  card_kind_i,
  input  logic [7:0]  entry_index_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        present_o,
  output logic [3:0]  match_index_o,
  output logic [4:0]  entry_total_o,
  output logic [63:0] read_low_o,
  output logic [15:0] read_high_o,
  output logic [3:0]  read_length_o,
  output logic [7:0]  read_kind_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // bits kept in storage: bytes beyond the configured identifier size are zero
  function automatic logic [uwt_pkg::IdBitsMax-1:0] keep_mask(int unsigned n);
    logic [uwt_pkg::IdBitsMax-1:0] m;
    m = '0;
    for (int unsigned b = 0; b < uwt_pkg::IdBytesMax; b++) begin
      if (b < n) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  localparam logic [uwt_pkg::IdBitsMax-1:0] KeepMask = keep_mask(ID_BYTES);

  uwt_pkg::ctl_state_e             state_q, state_d;
  uwt_pkg::action_e                act_q;
  uwt_pkg::entry_t                 key_q;
  logic [uwt_pkg::IdBytesMax-1:0]  byte_en_q, byte_en_d;
  logic                            len_ok_q, len_ok_d;
  logic [7:0]                      index_q;
  logic [CntW-1:0]                 count_q, count_d;
  logic [uwt_pkg::IdBitsMax-1:0]   id_kept;
  logic                            accept;

  uwt_pkg::cell_bcast_t            bcast;
  uwt_pkg::entry_t                 cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]          hit;
  logic                            found;
  logic [7:0]                      hit_pos;
  uwt_pkg::entry_t                 hit_entry;

  logic                            done_q, done_d;
  uwt_pkg::status_e                status_q, status_d;
  logic                            present_q, present_d;
  logic [3:0]                      mindex_q, mindex_d;
  uwt_pkg::entry_t                 rd_q, rd_d;
  logic [7:0]                      count_ext;

  assign accept = start_i && (state_q == uwt_pkg::CtlIdle);
  assign busy_o = (state_q != uwt_pkg::CtlIdle);

  // key preparation at the command beat
  always_comb begin
    id_kept = {id_high_i, id_low_i} & KeepMask;
    len_ok_d = (id_length_i != 4'd0) && (id_length_i <= 4'(ID_BYTES));
    for (int b = 0; b < uwt_pkg::IdBytesMax; b++) begin
      byte_en_d[b] = (4'(b) < id_length_i);
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q     <= uwt_pkg::action_e'(action_i);
      key_q.lo  <= id_kept[63:0];
      key_q.hi  <= id_kept[79:64];
      key_q.len <= id_length_i;
      key_q.kind <= card_kind_i;
      byte_en_q <= byte_en_d;
      len_ok_q  <= len_ok_d;
      index_q   <= entry_index_i;
    end
  end

  // cell row
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    uwt_pkg::entry_t next_entry;
    if (g + 1 < TABLE_DEPTH) begin : g_mid
      assign next_entry = cell_entry[g+1];
    end else begin : g_last
      assign next_entry = '0;
    end
    uwt_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast),
      .next_i  (next_entry),
      .entry_o (cell_entry[g]),
      .hit_o   (hit[g])
    );
  end

  // encode the single hit and pick its entry
  always_comb begin
    found     = 1'b0;
    hit_pos   = '0;
    hit_entry = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit[i]) begin
        found     = 1'b1;
        hit_pos   = hit_pos | 8'(i);
        hit_entry = hit_entry | cell_entry[i];
      end
    end
  end

  assign count_ext = 8'(count_q);

  // sequencer, cell broadcast and result
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = uwt_pkg::StInvalid;
    present_d = 1'b0;
    mindex_d  = '0;
    rd_d      = '0;
    bcast          = '0;
    bcast.key      = key_q;
    bcast.byte_en  = byte_en_q;
    bcast.count    = count_ext;
    bcast.by_index = (act_q == uwt_pkg::ActRead);
    unique case (state_q)
      uwt_pkg::CtlIdle: begin
        if (start_i) begin
          state_d = uwt_pkg::CtlSearch;
        end
      end
      uwt_pkg::CtlSearch: begin
        bcast.search = 1'b1;
        bcast.index  = index_q;
        state_d      = uwt_pkg::CtlApply;
      end
      uwt_pkg::CtlApply: begin
        state_d = uwt_pkg::CtlIdle;
        done_d  = 1'b1;
        unique case (act_q)
          uwt_pkg::ActAdd: begin
            priority if (!len_ok_q) begin
              status_d = uwt_pkg::StInvalid;
            end else if (found) begin
              status_d = uwt_pkg::StExists;
            end else if (count_q >= CntW'(TABLE_DEPTH)) begin
              status_d = uwt_pkg::StFull;
            end else begin
              bcast.append = 1'b1;
              bcast.index  = count_ext;
              count_d      = count_q + 1'b1;
              status_d     = uwt_pkg::StOk;
            end
          end
          uwt_pkg::ActRemove: begin
            priority if (!len_ok_q) begin
              status_d = uwt_pkg::StInvalid;
            end else if (!found) begin
              status_d = uwt_pkg::StMissing;
            end else begin
              bcast.shift = 1'b1;
              bcast.index = hit_pos;
              count_d     = count_q - 1'b1;
              status_d    = uwt_pkg::StOk;
            end
          end
          uwt_pkg::ActLookup: begin
            priority if (!len_ok_q) begin
              status_d = uwt_pkg::StInvalid;
            end else if (!found) begin
              status_d = uwt_pkg::StMissing;
            end else begin
              status_d  = uwt_pkg::StOk;
              present_d = 1'b1;
              mindex_d  = hit_pos[3:0];
            end
          end
          uwt_pkg::ActClear: begin
            count_d  = '0;
            status_d = uwt_pkg::StOk;
          end
          uwt_pkg::ActRead: begin
            if (found) begin
              status_d = uwt_pkg::StOk;
              rd_d     = hit_entry;
            end
          end
          default: begin
            status_d = uwt_pkg::StInvalid;
          end
        endcase
      end
      default: begin
        state_d = uwt_pkg::CtlIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uwt_pkg::CtlIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // result beat registers
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      status_q  <= status_d;
      present_q <= present_d;
      mindex_q  <= mindex_d;
      rd_q      <= rd_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign present_o     = present_q;
  assign match_index_o = mindex_q;
  assign entry_total_o = count_ext[4:0];
  assign read_low_o    = rd_q.lo;
  assign read_high_o   = rd_q.hi;
  assign read_length_o = rd_q.len;
  assign read_kind_o   = rd_q.kind;

  // no duplicates are ever stored, so at most one cell hits
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == uwt_pkg::CtlApply) |-> $onehot0(hit))
    else $error("more than one cell hit");

  // the count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // a result beat follows the update cycle only
  a_done_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == uwt_pkg::CtlApply))
    else $error("result beat without update cycle");

  // an accepted command goes straight to the compare cycle
  a_accept_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == uwt_pkg::CtlSearch))
    else $error("accepted command did not start a compare");

  // a successful add grows the table by one
  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == uwt_pkg::CtlApply && act_q == uwt_pkg::ActAdd &&
     status_d == uwt_pkg::StOk) |=> (count_q == $past(count_q) + 1'b1))
    else $error("add did not grow the table");

endmodule
